// ===== hdl/qrm_pkg.sv =====
// qrm_pkg: shared widths, types, constants and helpers for the quaternion to matrix block
package qrm_pkg;

  localparam int DATA_W  = 16;
  localparam int SCALE_W = 16;
  localparam int FRAC_W  = 14;
  localparam int PROD_W  = 2 * DATA_W;
  localparam int NORM_W  = PROD_W + 1;
  localparam int TERM_W  = PROD_W + 1;
  localparam int NUM_W   = TERM_W + SCALE_W + 1;
  localparam int REM_W   = NUM_W;
  localparam int QBITS   = DATA_W - 1;
  localparam int LANES   = 9;

  // stages: two in qrm_terms, three in qrm_numer, overflow check plus one per
  // quotient bit in qrm_div, one output register
  localparam int LATENCY = 2 + 3 + (QBITS + 1) + 1;

  typedef logic signed [DATA_W-1:0] q14_t;
  typedef logic [SCALE_W-1:0]       scale_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic [NORM_W-1:0]        norm_t;
  typedef logic signed [TERM_W-1:0] term_t;
  typedef logic signed [NUM_W-1:0]  num_t;
  typedef logic [REM_W-1:0]         rem_t;
  typedef logic [QBITS-1:0]         quot_t;

  localparam q14_t   ONE_Q14      = q14_t'(1 << FRAC_W);
  localparam q14_t   Q14_MAX      = q14_t'((1 << (DATA_W - 1)) - 1);
  localparam q14_t   Q14_MIN      = q14_t'(-(1 << (DATA_W - 1)));
  localparam scale_t SCALE_RESET  = scale_t'(2 << FRAC_W);

  typedef struct packed {
    logic valid;
    q14_t x;
    q14_t y;
    q14_t z;
    q14_t w;
  } quat_t;

  typedef struct packed {
    logic                    valid;
    norm_t                   norm;
    term_t [LANES-1:0]       term;
  } term_bus_t;

  typedef struct packed {
    logic                    valid;
    norm_t                   norm;
    rem_t  [LANES-1:0]       a;
    logic  [LANES-1:0]       neg;
  } numer_bus_t;

  typedef struct packed {
    logic                    valid;
    logic                    zero;
    quot_t [LANES-1:0]       quot;
    logic  [LANES-1:0]       neg;
    logic  [LANES-1:0]       ovf;
  } div_bus_t;

  // row-major lanes on the main diagonal
  function automatic logic is_diag(input int k);
    return (k == 0) || (k == 4) || (k == 8);
  endfunction

  // twice the norm, shifted up by the weight of one quotient bit
  function automatic rem_t div_trial(input norm_t n, input int sh);
    return rem_t'({n, 1'b0}) << sh;
  endfunction

endpackage

// ===== hdl/qrm_terms.sv =====
// qrm_terms: component products and the squared norm with the nine entry terms
module qrm_terms (
  input  logic                clk,
  input  logic                rst,
  input  qrm_pkg::quat_t      in_q,
  output qrm_pkg::term_bus_t  out_bus
);

  qrm_pkg::prod_t xx, yy, zz, ww, xy, xz, yz, xw, yw, zw;
  logic           v1;

  qrm_pkg::norm_t norm;
  qrm_pkg::term_t term [qrm_pkg::LANES];
  logic           v2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= in_q.valid;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    xx <= qrm_pkg::prod_t'(in_q.x) * qrm_pkg::prod_t'(in_q.x);
    yy <= qrm_pkg::prod_t'(in_q.y) * qrm_pkg::prod_t'(in_q.y);
    zz <= qrm_pkg::prod_t'(in_q.z) * qrm_pkg::prod_t'(in_q.z);
    ww <= qrm_pkg::prod_t'(in_q.w) * qrm_pkg::prod_t'(in_q.w);
    xy <= qrm_pkg::prod_t'(in_q.x) * qrm_pkg::prod_t'(in_q.y);
    xz <= qrm_pkg::prod_t'(in_q.x) * qrm_pkg::prod_t'(in_q.z);
    yz <= qrm_pkg::prod_t'(in_q.y) * qrm_pkg::prod_t'(in_q.z);
    xw <= qrm_pkg::prod_t'(in_q.x) * qrm_pkg::prod_t'(in_q.w);
    yw <= qrm_pkg::prod_t'(in_q.y) * qrm_pkg::prod_t'(in_q.w);
    zw <= qrm_pkg::prod_t'(in_q.z) * qrm_pkg::prod_t'(in_q.w);
  end

  always_ff @(posedge clk) begin
    norm    <= qrm_pkg::norm_t'(ww) + qrm_pkg::norm_t'(zz)
             + qrm_pkg::norm_t'(xx) + qrm_pkg::norm_t'(yy);
    term[0] <= qrm_pkg::term_t'(yy) + qrm_pkg::term_t'(zz);
    term[1] <= qrm_pkg::term_t'(xy) - qrm_pkg::term_t'(zw);
    term[2] <= qrm_pkg::term_t'(xz) + qrm_pkg::term_t'(yw);
    term[3] <= qrm_pkg::term_t'(xy) + qrm_pkg::term_t'(zw);
    term[4] <= qrm_pkg::term_t'(xx) + qrm_pkg::term_t'(zz);
    term[5] <= qrm_pkg::term_t'(yz) - qrm_pkg::term_t'(xw);
    term[6] <= qrm_pkg::term_t'(xz) - qrm_pkg::term_t'(yw);
    term[7] <= qrm_pkg::term_t'(yz) + qrm_pkg::term_t'(xw);
    term[8] <= qrm_pkg::term_t'(xx) + qrm_pkg::term_t'(yy);
  end

  always_comb begin
    out_bus.valid = v2;
    out_bus.norm  = norm;
    for (int k = 0; k < qrm_pkg::LANES; k++) begin
      out_bus.term[k] = term[k];
    end
  end

endmodule

// ===== hdl/qrm_numer.sv =====
// qrm_numer: scaling, diagonal numerators and the rounded dividend for each entry
module qrm_numer (
  input  logic                 clk,
  input  logic                 rst,
  input  qrm_pkg::scale_t      scale,
  input  qrm_pkg::term_bus_t   in_bus,
  output qrm_pkg::numer_bus_t  out_bus
);

  localparam int LANES = qrm_pkg::LANES;

  qrm_pkg::num_t  sp [LANES];
  qrm_pkg::norm_t norm3;
  logic           v3;

  qrm_pkg::num_t  num [LANES];
  qrm_pkg::norm_t norm4;
  logic           v4;

  qrm_pkg::rem_t  a [LANES];
  logic           neg [LANES];
  qrm_pkg::norm_t norm5;
  logic           v5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      v3 <= in_bus.valid;
      v4 <= v3;
      v5 <= v4;
    end
  end

  // scale times term
  always_ff @(posedge clk) begin
    norm3 <= in_bus.norm;
    for (int k = 0; k < LANES; k++) begin
      sp[k] <= qrm_pkg::num_t'($signed({1'b0, scale})) * qrm_pkg::num_t'(in_bus.term[k]);
    end
  end

  // diagonal entries: one times norm minus the scaled term
  always_ff @(posedge clk) begin
    norm4 <= norm3;
    for (int k = 0; k < LANES; k++) begin
      if (qrm_pkg::is_diag(k)) begin
        num[k] <= (qrm_pkg::num_t'(norm3) <<< qrm_pkg::FRAC_W) - sp[k];
      end else begin
        num[k] <= sp[k];
      end
    end
  end

  // dividend 2|num| + n, divisor 2n gives round half away from zero
  always_ff @(posedge clk) begin
    norm5 <= norm4;
    for (int k = 0; k < LANES; k++) begin
      neg[k] <= num[k][qrm_pkg::NUM_W-1];
      if (num[k][qrm_pkg::NUM_W-1]) begin
        a[k] <= qrm_pkg::rem_t'(norm4) - qrm_pkg::rem_t'(num[k] <<< 1);
      end else begin
        a[k] <= qrm_pkg::rem_t'(norm4) + qrm_pkg::rem_t'(num[k] <<< 1);
      end
    end
  end

  always_comb begin
    out_bus.valid = v5;
    out_bus.norm  = norm5;
    for (int k = 0; k < LANES; k++) begin
      out_bus.a[k]   = a[k];
      out_bus.neg[k] = neg[k];
    end
  end

endmodule

// ===== hdl/qrm_div.sv =====
// qrm_div: pipelined restoring divider bank, one quotient bit per stage for all entries
module qrm_div (
  input  logic                 clk,
  input  logic                 rst,
  input  qrm_pkg::numer_bus_t  in_bus,
  output qrm_pkg::div_bus_t    out_bus
);

  localparam int LANES = qrm_pkg::LANES;
  localparam int QBITS = qrm_pkg::QBITS;

  qrm_pkg::rem_t  rem  [QBITS+1][LANES];
  qrm_pkg::quot_t quot [QBITS+1][LANES];
  logic           neg  [QBITS+1][LANES];
  logic           ovf  [QBITS+1][LANES];
  qrm_pkg::norm_t norm [QBITS+1];
  logic [QBITS:0] vld;

  qrm_pkg::rem_t  diff [QBITS][LANES];
  logic           ge   [QBITS][LANES];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[QBITS-1:0], in_bus.valid};
    end
  end

  always_comb begin
    for (int j = 0; j < QBITS; j++) begin
      for (int k = 0; k < LANES; k++) begin
        ge[j][k]   = rem[j][k] >= qrm_pkg::div_trial(norm[j], QBITS - 1 - j);
        diff[j][k] = rem[j][k] - qrm_pkg::div_trial(norm[j], QBITS - 1 - j);
      end
    end
  end

  // first stage: flags a quotient that does not fit the field, which saturates at the output
  always_ff @(posedge clk) begin
    norm[0] <= in_bus.norm;
    for (int k = 0; k < LANES; k++) begin
      rem[0][k]  <= in_bus.a[k];
      quot[0][k] <= '0;
      neg[0][k]  <= in_bus.neg[k];
      ovf[0][k]  <= in_bus.a[k] >= qrm_pkg::div_trial(in_bus.norm, QBITS);
    end
    for (int j = 0; j < QBITS; j++) begin
      norm[j+1] <= norm[j];
      for (int k = 0; k < LANES; k++) begin
        neg[j+1][k] <= neg[j][k];
        ovf[j+1][k] <= ovf[j][k];
        if (ge[j][k]) begin
          rem[j+1][k]  <= diff[j][k];
          quot[j+1][k] <= quot[j][k] | (qrm_pkg::quot_t'(1) << (QBITS - 1 - j));
        end else begin
          rem[j+1][k]  <= rem[j][k];
          quot[j+1][k] <= quot[j][k];
        end
      end
    end
  end

  always_comb begin
    out_bus.valid = vld[QBITS];
    out_bus.zero  = (norm[QBITS] == '0);
    for (int k = 0; k < LANES; k++) begin
      out_bus.quot[k] = quot[QBITS][k];
      out_bus.neg[k]  = neg[QBITS][k];
      out_bus.ovf[k]  = ovf[QBITS][k];
    end
  end

endmodule

// ===== hdl/quaternion_to_rotation_matrix.sv =====
// quaternion_to_rotation_matrix: top level, scale register, pipeline and output register
//
//   channel   direction  handshake              payload
//   input     in         start, busy            quat_x quat_y quat_z quat_w
//   result    out        done (one-cycle pulse) m00..m22, zero_norm
//   config    in         cfg_we                 cfg_wdata (scale_factor)
//
// one quaternion may enter every cycle while busy is low; each result pulses done
// pipeline: 2 product/sum stages, 3 numerator stages, 16 divider stages, 1 output
// the divider bank resolves one quotient bit per stage for all nine entries
// the receiver cannot hold results off, so the pipeline never stalls
// busy is high only during reset and the cycle after it
// reset clears valid bits and sets scale_factor to 2.0
module quaternion_to_rotation_matrix (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  qrm_pkg::q14_t   quat_x,
  input  qrm_pkg::q14_t   quat_y,
  input  qrm_pkg::q14_t   quat_z,
  input  qrm_pkg::q14_t   quat_w,
  input  logic            cfg_we,
  input  qrm_pkg::scale_t cfg_wdata,
  output logic            done,
  output qrm_pkg::q14_t   m00,
  output qrm_pkg::q14_t   m01,
  output qrm_pkg::q14_t   m02,
  output qrm_pkg::q14_t   m10,
  output qrm_pkg::q14_t   m11,
  output qrm_pkg::q14_t   m12,
  output qrm_pkg::q14_t   m20,
  output qrm_pkg::q14_t   m21,
  output qrm_pkg::q14_t   m22,
  output logic            zero_norm
);

  localparam int LANES = qrm_pkg::LANES;

  qrm_pkg::scale_t     scale_factor;
  qrm_pkg::quat_t      in_q;
  qrm_pkg::term_bus_t  term_bus;
  qrm_pkg::numer_bus_t numer_bus;
  qrm_pkg::div_bus_t   div_bus;
  qrm_pkg::q14_t       m [LANES];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_factor <= qrm_pkg::SCALE_RESET;
    end else if (cfg_we) begin
      scale_factor <= cfg_wdata;
    end
  end

  always_comb begin
    in_q.valid = start && !busy;
    in_q.x     = quat_x;
    in_q.y     = quat_y;
    in_q.z     = quat_z;
    in_q.w     = quat_w;
  end

  qrm_terms u_terms (
    .clk     (clk),
    .rst     (rst),
    .in_q    (in_q),
    .out_bus (term_bus)
  );

  qrm_numer u_numer (
    .clk     (clk),
    .rst     (rst),
    .scale   (scale_factor),
    .in_bus  (term_bus),
    .out_bus (numer_bus)
  );

  qrm_div u_div (
    .clk     (clk),
    .rst     (rst),
    .in_bus  (numer_bus),
    .out_bus (div_bus)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= div_bus.valid;
    end
  end

  // sign, saturation and the identity for a zero norm
  always_ff @(posedge clk) begin
    zero_norm <= div_bus.zero;
    for (int k = 0; k < LANES; k++) begin
      if (div_bus.zero) begin
        m[k] <= qrm_pkg::is_diag(k) ? qrm_pkg::ONE_Q14 : '0;
      end else if (div_bus.ovf[k]) begin
        m[k] <= div_bus.neg[k] ? qrm_pkg::Q14_MIN : qrm_pkg::Q14_MAX;
      end else if (div_bus.neg[k]) begin
        m[k] <= -qrm_pkg::q14_t'({1'b0, div_bus.quot[k]});
      end else begin
        m[k] <= qrm_pkg::q14_t'({1'b0, div_bus.quot[k]});
      end
    end
  end

  assign m00 = m[0];
  assign m01 = m[1];
  assign m02 = m[2];
  assign m10 = m[3];
  assign m11 = m[4];
  assign m12 = m[5];
  assign m20 = m[6];
  assign m21 = m[7];
  assign m22 = m[8];

`ifndef SYNTHESIS
  a_done_follows_transfer: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, qrm_pkg::LATENCY))
    else $error("result without a matching input transfer");

  a_zero_norm_identity: assert property (@(posedge clk) disable iff (rst)
    done && zero_norm |-> m00 == qrm_pkg::ONE_Q14 && m11 == qrm_pkg::ONE_Q14
      && m22 == qrm_pkg::ONE_Q14 && m01 == '0 && m02 == '0 && m10 == '0
      && m12 == '0 && m20 == '0 && m21 == '0)
    else $error("zero norm result is not the identity");

  a_ready_after_reset: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> !busy)
    else $error("busy outside reset");
`endif

endmodule
